// ===== sv/lte_pkg.sv =====
// Shared types and constants for the LSB text embedder.
// No dependencies; imported by every module of the block.
package lte_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int BUFFER_BITS = 16;
    localparam int COUNT_W     = 5;
    localparam int CFG_W       = 4;
    localparam int CHAN_W      = 8;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_PIXEL   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    typedef enum logic [2:0] {
        ST_EMBEDDED      = 3'd0,
        ST_PASSED_DONE   = 3'd1,
        ST_UNDERRUN      = 3'd2,
        ST_BYTE_TAKEN    = 3'd3,
        ST_BYTE_REJECTED = 3'd4,
        ST_RESTARTED     = 3'd5
    } status_t;

    typedef struct packed {
        logic [BUFFER_BITS-1:0] buffer;
        logic [COUNT_W-1:0]     count;
        logic                   ended;
    } embed_state_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan2;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan0;
        status_t           status;
    } result_t;

endpackage

// ===== sv/lte_step.sv =====
// Combinational step logic: next message state and result for one item.
// Depends on lte_pkg.
module lte_step
    import lte_pkg::*;
(
    input  embed_state_t       state,
    input  logic [1:0]         operation,
    input  logic [7:0]         message_byte,
    input  logic               last_byte,
    input  logic [CHAN_W-1:0]  chan0_in,
    input  logic [CHAN_W-1:0]  chan1_in,
    input  logic [CHAN_W-1:0]  chan2_in,
    input  logic [CFG_W-1:0]   bits_per_channel,
    output embed_state_t       state_next,
    output result_t            result
);

    logic [3:0]             n_eff;
    logic [COUNT_W-1:0]     n_wide;
    logic [CHAN_W-1:0]      mask;
    logic [CHAN_W-1:0]      bits;
    logic [COUNT_W-1:0]     take;
    logic [23:0]            loaded;
    logic                   enough;

    always_comb
    begin
        // Zero acts as one bit, anything above eight as eight.
        if (bits_per_channel == '0)
            n_eff = 4'd1;
        else if (bits_per_channel > 4'(BYTE_BITS))
            n_eff = 4'(BYTE_BITS);
        else
            n_eff = bits_per_channel;
    end

    assign n_wide = {1'b0, n_eff};
    assign mask   = 8'hFF >> (4'(BYTE_BITS) - n_eff);
    assign bits   = state.buffer[CHAN_W-1:0] & mask;
    assign take   = (state.count >= n_wide) ? n_wide : state.count;
    assign enough = (state.count >= n_wide) || (state.ended && state.count != '0);
    assign loaded = {8'd0, state.buffer} | ({16'd0, message_byte} << state.count);

    always_comb
    begin
        state_next    = state;
        result.chan0  = '0;
        result.chan1  = '0;
        result.chan2  = '0;
        result.status = ST_BYTE_REJECTED;
        unique case (operation)
            OP_LOAD:
            begin
                if (!state.ended && state.count <= COUNT_W'(BUFFER_BITS - BYTE_BITS))
                begin
                    state_next.buffer = loaded[BUFFER_BITS-1:0];
                    state_next.count  = state.count + COUNT_W'(BYTE_BITS);
                    state_next.ended  = last_byte;
                    result.status     = ST_BYTE_TAKEN;
                end
            end
            OP_PIXEL:
            begin
                result.chan0 = chan0_in;
                result.chan1 = chan1_in;
                result.chan2 = chan2_in;
                if (enough)
                begin
                    result.chan0      = (chan0_in & ~mask) | bits;
                    result.chan1      = (chan1_in & ~mask) | bits;
                    result.chan2      = (chan2_in & ~mask) | bits;
                    state_next.buffer = state.buffer >> take;
                    state_next.count  = state.count - take;
                    result.status     = ST_EMBEDDED;
                end
                else if (state.ended)
                    result.status = ST_PASSED_DONE;
                else
                    result.status = ST_UNDERRUN;
            end
            OP_RESTART:
            begin
                state_next    = '0;
                result.status = ST_RESTARTED;
            end
            default:
            begin
                result.status = ST_BYTE_REJECTED;
            end
        endcase
    end

endmodule

// ===== sv/lsb_text_embedder_core.sv =====
// LSB text embedder core: one item per cycle while s_tready is high; results are registered.
// Each result is registered into the output buffer before it is shown on m_tvalid.
// Throughput: 1 item per cycle; a two-entry output buffer keeps s_tready high
// while one result waits, so the combinational step logic sets the rate.
// Reset (rst_n, asynchronous, active low) empties the buffer, clears the
// message state and sets bits_per_channel to 1. Depends on lte_pkg, lte_step.
module lsb_text_embedder_core
    import lte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // message_byte, chan0_in, chan1_in, chan2_in
    input  logic [1:0]  s_tuser,   // operation
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // chan0_out, chan1_out, chan2_out
    output logic [2:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // bits_per_channel
);

    embed_state_t       state_reg;
    embed_state_t       state_next;
    logic [CFG_W-1:0]   bits_reg;
    result_t            step_result;
    result_t            main_reg;
    result_t            skid_reg;
    logic               main_valid_reg;
    logic               skid_valid_reg;
    logic               accept;
    logic               pop;

    lte_step u_step (
        .state            (state_reg),
        .operation        (s_tuser),
        .message_byte     (s_tdata[7:0]),
        .last_byte        (s_tlast),
        .chan0_in         (s_tdata[15:8]),
        .chan1_in         (s_tdata[23:16]),
        .chan2_in         (s_tdata[31:24]),
        .bits_per_channel (bits_reg),
        .state_next       (state_next),
        .result           (step_result)
    );

    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign pop       = main_valid_reg && m_tready;

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {main_reg.chan2, main_reg.chan1, main_reg.chan0};
    assign m_tuser  = main_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            bits_reg  <= 4'd1;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (cfg_valid)
                bits_reg <= cfg_data;
        end
    end

    // The skid entry only fills when the main entry is held by the far side.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    main_valid_reg <= accept;
            end
            else if (accept)
            begin
                if (main_valid_reg)
                    skid_valid_reg <= 1'b1;
                else
                    main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (accept)
                main_reg <= step_result;
        end
        else if (accept)
        begin
            if (main_valid_reg)
                skid_reg <= step_result;
            else
                main_reg <= step_result;
        end
    end

endmodule

// ===== sv/lte_checker.sv =====
// Port-level checker for lsb_text_embedder_core, attached by a bind statement.
// Depends on lte_pkg and on the top level's port list.
module lte_checker
    import lte_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped during a stall");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed during a stall");

    a_one_cycle : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("result missing one cycle after a transfer into an empty block");

    a_ready_only_stalled : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
        else $error("s_tready low without a stalled result");

    a_zero_channels : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_EMBEDDED && m_tuser != ST_PASSED_DONE
            && m_tuser != ST_UNDERRUN |-> m_tdata == '0)
        else $error("non-pixel result carries channel data");

endmodule

bind lsb_text_embedder_core lte_checker u_lte_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lsb_text_embedder_core: a tracker class predicts every result
// and compares it with the master stream; plain tasks drive the slave stream and the register.
// Depends on lte_pkg and the block's RTL.
module tb_top;
    import lte_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_SHOWN = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 800;

    typedef struct {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic [2:0] status;
    } pixel_result_t;

    class lsb_embed_tracker;
        logic [3:0]    bits_cfg;
        logic [15:0]   bit_buffer;
        logic [4:0]    bit_count;
        bit            ended;
        pixel_result_t awaited[$];
        int            failures;

        function new();
            bits_cfg = 4'd1;
            bit_buffer = '0;
            bit_count = '0;
            ended = 1'b0;
            failures = 0;
        endfunction

        function void set_bits(logic [3:0] value);
            bits_cfg = value;
        endfunction

        function int lane_bits();
            if (bits_cfg == 4'd0)
                return 1;
            if (bits_cfg > 4'd8)
                return 8;
            return int'(bits_cfg);
        endfunction

        // True when the next pixel would carry message bits.
        function bit will_embed();
            return (bit_count >= lane_bits()) || (ended && bit_count > 0);
        endfunction

        function void take_item(logic [1:0] op, logic [7:0] mbyte, logic lastb,
                                logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            pixel_result_t r;
            logic [8:0]    wide_mask;
            logic [7:0]    mask;
            logic [7:0]    bits;
            int            n;
            int            take;

            r.chan0 = '0;
            r.chan1 = '0;
            r.chan2 = '0;
            case (op)
                OP_LOAD:
                begin
                    if (ended || bit_count > 5'd8)
                        r.status = ST_BYTE_REJECTED;
                    else
                    begin
                        bit_buffer = bit_buffer | ({8'h00, mbyte} << bit_count);
                        bit_count = bit_count + 5'd8;
                        if (lastb)
                            ended = 1'b1;
                        r.status = ST_BYTE_TAKEN;
                    end
                end
                OP_PIXEL:
                begin
                    n = lane_bits();
                    wide_mask = (9'd1 << n) - 9'd1;
                    mask = wide_mask[7:0];
                    r.chan0 = c0;
                    r.chan1 = c1;
                    r.chan2 = c2;
                    if (will_embed())
                    begin
                        take = (bit_count >= n) ? n : int'(bit_count);
                        bits = bit_buffer[7:0] & mask;
                        r.chan0 = (c0 & ~mask) | bits;
                        r.chan1 = (c1 & ~mask) | bits;
                        r.chan2 = (c2 & ~mask) | bits;
                        bit_buffer = bit_buffer >> take;
                        bit_count = bit_count - 5'(take);
                        r.status = ST_EMBEDDED;
                    end
                    else if (ended)
                        r.status = ST_PASSED_DONE;
                    else
                        r.status = ST_UNDERRUN;
                end
                OP_RESTART:
                begin
                    bit_buffer = '0;
                    bit_count = '0;
                    ended = 1'b0;
                    r.status = ST_RESTARTED;
                end
                default:
                    r.status = ST_BYTE_REJECTED;
            endcase
            awaited.push_back(r);
        endfunction

        function void compare_result(logic [23:0] data, logic [2:0] status);
            pixel_result_t want;

            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("%0t: result with nothing awaited: chans %h %h %h status %0d",
                             $realtime, data[7:0], data[15:8], data[23:16], status);
                return;
            end
            want = awaited.pop_front();
            if (data[7:0] !== want.chan0 || data[15:8] !== want.chan1
                || data[23:16] !== want.chan2 || status !== want.status)
            begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("%0t: mismatch: expected chans %h %h %h status %0d, got %h %h %h status %0d",
                             $realtime, want.chan0, want.chan1, want.chan2, want.status,
                             data[7:0], data[15:8], data[23:16], status);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // message_byte, chan0_in, chan1_in, chan2_in
    logic [1:0]  s_tuser;   // operation
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // chan0_out, chan1_out, chan2_out
    logic [2:0]  m_tuser;   // status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;  // bits_per_channel

    lsb_embed_tracker tracker;
    bit quiet;
    int items_sent;

    lsb_text_embedder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("lsb_text_embedder_core verification failed");
        $finish;
    end

    // The receiver stalls in random bursts unless the run is quiet.
    initial
    begin
        int stall_left;

        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                m_tready = 1'b0;
                stall_left = $urandom_range(0, 4);
            end
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.compare_result(m_tdata, m_tuser);
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] mbyte, input logic lastb,
                             input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tlast = lastb;
        s_tdata = {c2, c1, c0, mbyte};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.take_item(op, mbyte, lastb, c0, c1, c2);
        items_sent++;
    endtask

    task automatic send_rand(input logic [1:0] op, input logic lastb);
        send_item(op, 8'($urandom), lastb, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_bits(input logic [3:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_bits(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One message: mostly a clean restart, loads with pixels in between, a final byte
    // and enough pixels to flush the tail, with some noise and misuse mixed in.
    task automatic run_message();
        int nbytes;

        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
                send_rand(2'($urandom), 1'($urandom));
        if ($urandom_range(0, 3) != 0)
            send_rand(OP_RESTART, 1'($urandom));
        nbytes = $urandom_range(1, 6);
        for (int k = 0; k < nbytes; k++)
        begin
            if ($urandom_range(0, 7) != 0)
                while (tracker.bit_count > 5'd8)
                    send_rand(OP_PIXEL, 1'($urandom));
            send_rand(OP_LOAD, k == nbytes - 1);
            repeat ($urandom_range(0, 3))
                send_rand(OP_PIXEL, 1'($urandom));
        end
        while (tracker.will_embed())
            send_rand(OP_PIXEL, 1'($urandom));
        repeat ($urandom_range(0, 2))
            send_rand(OP_PIXEL, 1'($urandom));
        if ($urandom_range(0, 4) == 0)
            send_rand(OP_LOAD, 1'($urandom));
    endtask

    initial
    begin
        logic [3:0] phase_bits[11];
        int target;

        phase_bits = '{4'd8, 4'd0, 4'd15, 4'd9, 4'd2, 4'd5, 4'd7, 4'd4, 4'd6, 4'd1, 4'd3};
        tracker = new();
        quiet = 1'b0;
        items_sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset setting of one bit per channel.
        send_item(OP_PIXEL, 8'h00, 1'b0, 8'h00, 8'hFF, 8'h00);
        send_item(OP_LOAD, 8'h00, 1'b0, 8'hFF, 8'h00, 8'hFF);
        send_item(OP_LOAD, 8'hFF, 1'b0, 8'h00, 8'hFF, 8'h00);
        // Buffer full: rejected, and the last flag must be ignored.
        send_item(OP_LOAD, 8'hA5, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_PIXEL, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_PIXEL, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        send_item(OP_RESTART, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
        send_item(OP_LOAD, 8'h5A, 1'b1, 8'h00, 8'h00, 8'h00);
        // A byte after the end of the message is rejected.
        send_item(OP_LOAD, 8'h33, 1'b0, 8'h00, 8'h00, 8'h00);
        for (int k = 0; k < 8; k++)
            send_item(OP_PIXEL, 8'h00, 1'b0, k[0] ? 8'hFF : 8'h00, 8'hAA, k[0] ? 8'h00 : 8'hFF);
        send_item(OP_PIXEL, 8'h00, 1'b0, 8'h12, 8'h34, 8'h56);
        send_item(OP_RESTART, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);

        // Three bits per channel leave a two-bit tail that is padded with zeros.
        write_bits(4'd3);
        send_item(OP_LOAD, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00);
        repeat (4)
            send_item(OP_PIXEL, 8'h00, 1'b0, 8'hFF, 8'h00, 8'hFF);

        target = 0;
        for (int p = 0; p < 11; p++)
        begin
            write_bits(phase_bits[p]);
            if (p >= 9)
                quiet = 1'b1;
            target += RANDOM_ITEMS / 11;
            while (items_sent < target + 25)
            begin
                if (p < 9)
                    quiet = ($urandom_range(0, 4) == 0);
                run_message();
            end
        end

        wait_drained();
        if (tracker.failures == 0)
            $display("lsb_text_embedder_core verification clean");
        else
            $display("lsb_text_embedder_core verification failed");
        $finish;
    end

endmodule
